// ===== hw/rtl/sspq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and codes for the stable sorted priority queue unit.
// ----------------------------------------------------------------------------
package sspq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int ACTION_W = 2;
	localparam int KEY_W    = 8;
	localparam int ID_W     = 16;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;

	localparam logic [ACTION_W-1:0] ACT_SORTED = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FRONT  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_BACK   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_POP    = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic capture; // latch the item and the per-cell position flags
		logic apply;   // carry out the operation on the cell row
	} dp_cmd_t;

endpackage

// ===== hw/rtl/stable_sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Bounded queue of key/id entries with stable sorted insert, push front,
// push back and pop front. One result per item.
// ----------------------------------------------------------------------------
//  channel  | handshake      | fields
//  ---------+----------------+--------------------------------------------
//  item in  | start && !busy | action, sort_key, customer_id
//  result   | done (1 cycle) | status, popped_key, popped_id, fill_count
//
//  On accept the per-cell compare flags are registered; in ST_APPLY the cell row
//  is shifted and the result registers and done are set together.
//  A new item may be started in the same cycle that done is shown.
//  Reset (arst_n low) empties the queue; cell contents are not cleared.
//  The receiver takes every result; there is no output stall.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_unit #(
	parameter int DEPTH = sspq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [sspq_pkg::ACTION_W-1:0] action,
	input  logic [sspq_pkg::KEY_W-1:0]    sort_key,
	input  logic [sspq_pkg::ID_W-1:0]     customer_id,
	output logic                          done,
	output logic [sspq_pkg::STATUS_W-1:0] status,
	output logic [sspq_pkg::KEY_W-1:0]    popped_key,
	output logic [sspq_pkg::ID_W-1:0]     popped_id,
	output logic [sspq_pkg::FILL_W-1:0]   fill_count
);

	sspq_pkg::dp_cmd_t cmd;

	sspq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	sspq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (action),
		.sort_key    (sort_key),
		.customer_id (customer_id),
		.status      (status),
		.popped_key  (popped_key),
		.popped_id   (popped_id),
		.fill_count  (fill_count)
	);

endmodule

// ===== hw/rtl/sspq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspq_datapath
// Row of key/id cells with parallel compare, prefix-OR slot select and
// shift-in / shift-out, plus the entry count and result registers.
// ----------------------------------------------------------------------------
module sspq_datapath #(
	parameter int DEPTH = sspq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sspq_pkg::dp_cmd_t             cmd,
	input  logic [sspq_pkg::ACTION_W-1:0] action,
	input  logic [sspq_pkg::KEY_W-1:0]    sort_key,
	input  logic [sspq_pkg::ID_W-1:0]     customer_id,
	output logic [sspq_pkg::STATUS_W-1:0] status,
	output logic [sspq_pkg::KEY_W-1:0]    popped_key,
	output logic [sspq_pkg::ID_W-1:0]     popped_id,
	output logic [sspq_pkg::FILL_W-1:0]   fill_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LVLS  = $clog2(DEPTH);

	logic [sspq_pkg::KEY_W-1:0]    key_q [DEPTH];
	logic [sspq_pkg::ID_W-1:0]     id_q  [DEPTH];
	logic [CNT_W-1:0]              count_q;
	logic [sspq_pkg::ACTION_W-1:0] act_q;
	logic [sspq_pkg::KEY_W-1:0]    new_key_q;
	logic [sspq_pkg::ID_W-1:0]     new_id_q;
	logic [DEPTH-1:0]              flags_q;
	logic [sspq_pkg::STATUS_W-1:0] status_q;
	logic [sspq_pkg::KEY_W-1:0]    pkey_q;
	logic [sspq_pkg::ID_W-1:0]     pid_q;

	logic [DEPTH-1:0]       flags_c;
	logic [DEPTH-1:0]       pre [LVLS+1];
	logic [DEPTH-1:0]       shift_c;
	logic                   is_pop;
	logic                   empty;
	logic                   full;
	logic [CNT_W+sspq_pkg::FILL_W-1:0] fill_wide;

	// flag set on cell i: new entry goes at or before i
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			case (action)
				sspq_pkg::ACT_FRONT:  flags_c[i] = 1'b1;
				sspq_pkg::ACT_BACK:   flags_c[i] = (CNT_W'(i) >= count_q);
				sspq_pkg::ACT_SORTED: flags_c[i] = (CNT_W'(i) >= count_q) ||
				                                   (key_q[i] > sort_key);
				default:              flags_c[i] = 1'b0;
			endcase
		end
	end

	// log-depth prefix OR: cells at or after the insert slot
	always_comb begin
		pre[0] = flags_q;
		for (int l = 0; l < LVLS; l++) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (i >= (1 << l)) begin
					pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
				end else begin
					pre[l+1][i] = pre[l][i];
				end
			end
		end
		shift_c = pre[LVLS];
	end

	assign is_pop = (act_q == sspq_pkg::ACT_POP);
	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			if (is_pop) begin
				if (!empty) count_q <= count_q - CNT_W'(1);
			end else if (!full) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q     <= action;
			new_key_q <= sort_key;
			new_id_q  <= customer_id;
			flags_q   <= flags_c;
		end
		if (cmd.apply) begin
			status_q <= sspq_pkg::STATUS_OK;
			pkey_q   <= '0;
			pid_q    <= '0;
			if (is_pop) begin
				if (empty) begin
					status_q <= sspq_pkg::STATUS_EMPTY;
				end else begin
					pkey_q <= key_q[0];
					pid_q  <= id_q[0];
					for (int i = 0; i < DEPTH - 1; i++) begin
						key_q[i] <= key_q[i+1];
						id_q[i]  <= id_q[i+1];
					end
				end
			end else if (full) begin
				status_q <= sspq_pkg::STATUS_FULL;
			end else begin
				// first flagged cell takes the new entry, later ones shift back
				for (int i = 0; i < DEPTH; i++) begin
					if (i > 0 && shift_c[i] && shift_c[i-1]) begin
						key_q[i] <= key_q[i-1];
						id_q[i]  <= id_q[i-1];
					end else if (shift_c[i]) begin
						key_q[i] <= new_key_q;
						id_q[i]  <= new_id_q;
					end
				end
			end
		end
	end

	assign fill_wide  = {{sspq_pkg::FILL_W{1'b0}}, count_q};
	assign fill_count = fill_wide[sspq_pkg::FILL_W-1:0];
	assign status     = status_q;
	assign popped_key = pkey_q;
	assign popped_id  = pid_q;

endmodule

// ===== hw/rtl/sspq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspq_ctrl
// Two-state controller: accepts an item, then runs the apply state and
// raises the result strobe.
// ----------------------------------------------------------------------------
module sspq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output sspq_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_APPLY;
						busy_q  <= 1'b1;
					end
				end
				ST_APPLY: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.capture = accept;
	assign cmd.apply   = (state_q == ST_APPLY);
	assign busy        = busy_q;
	assign done        = done_q;

endmodule

// ===== hw/rtl/sspq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspq_checker
// Port-level checks on the queue unit's item and result timing.
// ----------------------------------------------------------------------------
module sspq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [sspq_pkg::STATUS_W-1:0] status,
	input logic [sspq_pkg::KEY_W-1:0]    popped_key,
	input logic [sspq_pkg::ID_W-1:0]     popped_id,
	input logic [sspq_pkg::FILL_W-1:0]   fill_count
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("result strobe missing after busy cycle");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in work");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != sspq_pkg::STATUS_OK |-> popped_key == '0 && popped_id == '0)
		else $error("rejected operation returned an entry");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == sspq_pkg::STATUS_EMPTY |-> fill_count == '0)
		else $error("empty status with nonzero fill count");

endmodule

bind stable_sorted_priority_queue_unit sspq_checker u_sspq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.popped_key (popped_key),
	.popped_id  (popped_id),
	.fill_count (fill_count)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_sorted_priority_queue_unit. A short table of
// directed items (empty pop, stable ties, front/back pushes, full queue) is
// followed by random items in blocks that lean to filling, holding or draining
// the queue. Every result field is checked vs a typed row or a shadow queue.
// ----------------------------------------------------------------------------
module tb;
	import sspq_pkg::*;

	localparam int QUEUE_DEPTH    = DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS   = 1950;
	localparam int WATCHDOG_LIMIT = 200;
	localparam int DRAIN_CYCLES   = 10;
	localparam int CALM_LO        = 600;  // item range issued with no idle gaps
	localparam int CALM_HI        = 1000;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [KEY_W-1:0]    sort_key;
		logic [ID_W-1:0]     customer_id;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    popped_key;
		logic [ID_W-1:0]     popped_id;
		logic [FILL_W-1:0]   fill_count;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	// directed row: issued reps times; known marks a hand-typed result
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [KEY_W-1:0]    sort_key;
		logic [ID_W-1:0]     customer_id;
		logic [4:0]          reps;
		logic                known;
		result_t             res;
	} row_t;

	localparam int N_ROWS = 26;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [ACTION_W-1:0] action = ACT_SORTED;
	logic [KEY_W-1:0] sort_key = '0;
	logic [ID_W-1:0] customer_id = '0;
	logic busy;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0] popped_key;
	logic [ID_W-1:0] popped_id;
	logic [FILL_W-1:0] fill_count;

	item_t   stim_items[$];
	bit      stim_known[$];
	result_t stim_typed[$];
	result_t pending_results[$];
	entry_t  shadow_entries[$];
	row_t    dir_table[N_ROWS];

	int issued = 0;
	int checked = 0;
	int quiet_cycles = 0;
	int fail_count = 0;
	int full_seen = 0;
	int empty_seen = 0;
	int dir_items = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stable_sorted_priority_queue_unit #(
		.DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.sort_key(sort_key),
		.customer_id(customer_id),
		.done(done),
		.status(status),
		.popped_key(popped_key),
		.popped_id(popped_id),
		.fill_count(fill_count)
	);

	// apply one item to the shadow queue and return the result it should give
	function automatic result_t apply_to_shadow(item_t it);
		result_t r;
		entry_t e;
		int pos;
		r = '0;
		r.status = STATUS_OK;
		e.key = it.sort_key;
		e.id = it.customer_id;
		if (it.action == ACT_POP) begin
			if (shadow_entries.size() == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				e = shadow_entries.pop_front();
				r.popped_key = e.key;
				r.popped_id = e.id;
			end
		end else if (shadow_entries.size() >= QUEUE_DEPTH) begin
			r.status = STATUS_FULL;
		end else begin
			case (it.action)
				ACT_FRONT: shadow_entries.push_front(e);
				ACT_BACK:  shadow_entries.push_back(e);
				default: begin
					// stable: walk past every key <= the new one
					pos = 0;
					while (pos < shadow_entries.size() && shadow_entries[pos].key <= e.key)
						pos++;
					shadow_entries.insert(pos, e);
				end
			endcase
		end
		r.fill_count = FILL_W'(shadow_entries.size());
		return r;
	endfunction

	task automatic queue_item(item_t it, bit known, result_t res);
		stim_items.push_back(it);
		stim_known.push_back(known);
		stim_typed.push_back(res);
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	// result check, item acceptance with prediction, and driving of the next item
	always @(posedge clk) begin : drive_and_check
		result_t want;
		result_t pred;
		int n;
		bit progress;
		bit may_idle;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			progress = 1'b0;
			n = issued;
			if (done) begin
				progress = 1'b1;
				if (pending_results.size() == 0) begin
					$error("result with no item outstanding: status %0h fill %0d",
						status, fill_count);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("popped_key", 32'(want.popped_key), 32'(popped_key));
					check_field("popped_id", 32'(want.popped_id), 32'(popped_id));
					check_field("fill_count", 32'(want.fill_count), 32'(fill_count));
					if (status == STATUS_FULL)
						full_seen++;
					if (status == STATUS_EMPTY)
						empty_seen++;
					checked++;
				end
			end
			if (start && !busy) begin
				progress = 1'b1;
				pred = apply_to_shadow(stim_items[n]);
				pending_results.push_back(stim_known[n] ? stim_typed[n] : pred);
				n++;
				issued <= n;
			end
			quiet_cycles <= progress ? 0 : quiet_cycles + 1;
			may_idle = !(n >= CALM_LO && n < CALM_HI);
			if (n < stim_items.size() && !(may_idle && $urandom_range(0, 99) < 13)) begin
				start <= 1'b1;
				action <= stim_items[n].action;
				sort_key <= stim_items[n].sort_key;
				customer_id <= stim_items[n].customer_id;
			end else begin
				start <= 1'b0;
			end
		end
	end

	initial begin
		item_t it;
		int pop_weights[5];
		int pop_pct;
		bit narrow;
		logic [KEY_W-1:0] key_base;
		int r;

		dir_table = '{
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_EMPTY, 8'h00, 16'h0000, 5'd0}},
			'{ACT_SORTED, 8'h80, 16'h1234, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd1}},
			'{ACT_SORTED, 8'hFF, 16'hFFFF, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd2}},
			'{ACT_SORTED, 8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd3}},
			// equal key lands after the earlier 0x80
			'{ACT_SORTED, 8'h80, 16'h5555, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd4}},
			'{ACT_FRONT,  8'h40, 16'hAAAA, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd5}},
			'{ACT_BACK,   8'h01, 16'h0001, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd6}},
			// queue out of order now: stops at the first greater key (front)
			'{ACT_SORTED, 8'h20, 16'h2020, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd7}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'h20, 16'h2020, 5'd6}},
			'{ACT_POP,    8'hFF, 16'hFFFF, 5'd1,  1'b1, '{STATUS_OK,    8'h40, 16'hAAAA, 5'd5}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd4}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'h80, 16'h1234, 5'd3}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'h80, 16'h5555, 5'd2}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'hFF, 16'hFFFF, 5'd1}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'h01, 16'h0001, 5'd0}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_EMPTY, 8'h00, 16'h0000, 5'd0}},
			'{ACT_FRONT,  8'hC3, 16'h3C3C, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd1}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'hC3, 16'h3C3C, 5'd0}},
			'{ACT_BACK,   8'h5A, 16'hA5A5, 5'd1,  1'b1, '{STATUS_OK,    8'h00, 16'h0000, 5'd1}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'h5A, 16'hA5A5, 5'd0}},
			'{ACT_BACK,   8'h7F, 16'h0F0F, 5'd16, 1'b0, '{STATUS_OK,    8'h00, 16'h0000, 5'd0}},
			'{ACT_SORTED, 8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_FULL,  8'h00, 16'h0000, 5'd16}},
			'{ACT_FRONT,  8'hFF, 16'hFFFF, 5'd1,  1'b1, '{STATUS_FULL,  8'h00, 16'h0000, 5'd16}},
			'{ACT_BACK,   8'hFF, 16'hFFFF, 5'd1,  1'b1, '{STATUS_FULL,  8'h00, 16'h0000, 5'd16}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd1,  1'b1, '{STATUS_OK,    8'h7F, 16'h0F0F, 5'd15}},
			'{ACT_POP,    8'h00, 16'h0000, 5'd15, 1'b0, '{STATUS_OK,    8'h00, 16'h0000, 5'd0}}
		};
		for (int i = 0; i < N_ROWS; i++) begin
			it.action = dir_table[i].action;
			it.sort_key = dir_table[i].sort_key;
			it.customer_id = dir_table[i].customer_id;
			repeat (dir_table[i].reps)
				queue_item(it, dir_table[i].known, dir_table[i].res);
		end
		dir_items = stim_items.size();

		// random blocks, each leaning toward filling, holding or draining the queue;
		// narrow key windows force many equal keys
		pop_weights = '{8, 35, 50, 65, 92};
		while (stim_items.size() < dir_items + RANDOM_ITEMS) begin
			pop_pct = pop_weights[$urandom_range(0, 4)];
			narrow = 1'($urandom_range(0, 1));
			key_base = KEY_W'($urandom);
			repeat ($urandom_range(20, 60)) begin
				if ($urandom_range(0, 99) < pop_pct) begin
					it.action = ACT_POP;
				end else begin
					r = $urandom_range(0, 99);
					it.action = (r < 60) ? ACT_SORTED : (r < 80) ? ACT_FRONT : ACT_BACK;
				end
				it.sort_key = narrow ? key_base + KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom);
				it.customer_id = ID_W'($urandom);
				queue_item(it, 1'b0, '0);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (!(issued == stim_items.size() && pending_results.size() == 0)
				&& quiet_cycles < WATCHDOG_LIMIT)
			@(negedge clk);

		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item or result for %0d cycles (%0d of %0d items issued)",
				WATCHDOG_LIMIT, issued, stim_items.size());
			$display("tb NOT OK");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (pending_results.size() != 0)
				$error("%0d results never arrived", pending_results.size());
			$display("%0d items issued (%0d directed), %0d results checked",
				issued, dir_items, checked);
			$display("inserts refused on full queue: %0d, pops refused on empty queue: %0d",
				full_seen, empty_seen);
			if (fail_count == 0 && pending_results.size() == 0)
				$display("tb OK");
			else
				$display("tb NOT OK");
		end
		$finish;
	end

endmodule
